@@ design/srnp_pkg.sv @@
// ----------------------------------------------------------------------------
// srnp_pkg
// Shared types and constants of the signed radix number parser: character
// codes, parse phases, radix codes and the classified character record.
// ----------------------------------------------------------------------------
package srnp_pkg;

    // widths and defaults
    localparam int VALUE_OUT_W       = 16;
    localparam int VALUE_WIDTH_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int CHAR_W            = 8;
    localparam int DIGIT_W           = 4;

    // ascii codes the parser cares about
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    // offset from the low nibble of a hex letter to its digit value
    localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd9;

    // parse phases
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_ZERO   = 3'd1,
        PH_HEXPFX = 3'd2,
        PH_HEX    = 3'd3,
        PH_BINPFX = 3'd4,
        PH_BIN    = 3'd5,
        PH_DEC    = 3'd6,
        PH_FAIL   = 3'd7
    } phase_t;

    // radix of a digit step
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } radix_t;

    // classified character, as queued between front and back
    typedef struct packed {
        logic               last;
        logic               is_minus;
        logic               is_zero;
        logic               is_x;
        logic               is_b;
        logic               is_dec;
        logic               is_hex;
        logic               is_bin;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

endpackage

@@ design/srnp_front.sv @@
// ----------------------------------------------------------------------------
// srnp_front
// Input side: takes one character request per cycle while the queue is not
// full, classifies it and pushes the classified record into the queue.
// ----------------------------------------------------------------------------
module srnp_front (
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [srnp_pkg::CHAR_W-1:0]   ch,
    input  logic                          last_char,
    input  logic                          q_full,
    output logic                          q_push,
    output srnp_pkg::char_class_t         q_wdata
);
    import srnp_pkg::*;

    logic is_lower_hex;
    logic is_upper_hex;

    // handshake toward the queue
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // character classes
    assign is_lower_hex = (ch >= CH_LA) && (ch <= CH_LF);
    assign is_upper_hex = (ch >= CH_UA) && (ch <= CH_UF);

    always_comb
    begin
        q_wdata          = '0;
        q_wdata.last     = last_char;
        q_wdata.is_minus = (ch == CH_MINUS);
        q_wdata.is_zero  = (ch == CH_0);
        q_wdata.is_x     = (ch == CH_LX) || (ch == CH_UX);
        q_wdata.is_b     = (ch == CH_LB);
        q_wdata.is_dec   = (ch >= CH_0) && (ch <= CH_9);
        q_wdata.is_bin   = (ch == CH_0) || (ch == CH_1);
        q_wdata.is_hex   = q_wdata.is_dec || is_lower_hex || is_upper_hex;
        // digit value: letters map low nibble 1..6 to 10..15
        if (is_lower_hex || is_upper_hex)
        begin
            q_wdata.digit = ch[DIGIT_W-1:0] + HEX_LETTER_OFS;
        end
        else
        begin
            q_wdata.digit = ch[DIGIT_W-1:0];
        end
    end

endmodule

@@ design/srnp_queue.sv @@
// ----------------------------------------------------------------------------
// srnp_queue
// Small first-in first-out queue of classified characters between the
// front and the back, so each side can stall on its own.
// ----------------------------------------------------------------------------
module srnp_queue #(
    parameter int DEPTH = srnp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srnp_pkg::char_class_t wdata,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output srnp_pkg::char_class_t rdata
);
    import srnp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    char_class_t       slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/srnp_back.sv @@
// ----------------------------------------------------------------------------
// srnp_back
// Parse engine: steps the phase machine on each queued character, runs the
// radix multiply-add with overflow detection, and holds the word result in
// an output register until it is taken.
// ----------------------------------------------------------------------------
module srnp_back #(
    parameter int VALUE_WIDTH = srnp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_not_empty,
    input  srnp_pkg::char_class_t                q_rdata,
    output logic                                 q_pop,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 ok,
    output logic signed [srnp_pkg::VALUE_OUT_W-1:0] value,
    output logic                                 overflow
);
    import srnp_pkg::*;

    localparam int PROD_W = VALUE_WIDTH + DIGIT_W;
    localparam int EXT_W  = VALUE_WIDTH + VALUE_OUT_W;

    phase_t                   phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0]   acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     ok_reg, ok_next;
    logic [VALUE_OUT_W-1:0]   value_reg, value_next;
    logic                     overflow_reg, overflow_next;

    phase_t                   step_phase;
    logic                     step_neg;
    logic                     do_add;
    radix_t                   radix;
    logic [PROD_W-1:0]        acc_ext;
    logic [PROD_W-1:0]        prod;
    logic [VALUE_WIDTH-1:0]   step_acc;
    logic                     step_ovf;
    logic                     word_ok;
    logic [EXT_W-1:0]         mag_ext;
    logic [VALUE_OUT_W-1:0]   mag16;

    // a request leaves the queue unless it ends a word and the result is blocked
    assign q_pop = q_not_empty && (!q_rdata.last || !out_valid_reg || !out_stall);

    // phase machine on the current character
    always_comb
    begin
        step_phase = phase_reg;
        step_neg   = neg_reg;
        do_add     = 1'b0;
        radix      = RADIX_DEC;
        case (phase_reg)
            PH_START:
            begin
                if (q_rdata.is_minus && !neg_reg)
                begin
                    step_neg = 1'b1;
                end
                else if (q_rdata.is_zero)
                begin
                    step_phase = PH_ZERO;
                end
                else if (q_rdata.is_dec)
                begin
                    do_add     = 1'b1;
                    step_phase = PH_DEC;
                end
                else if (q_rdata.is_b)
                begin
                    step_phase = PH_BINPFX;
                end
                else
                begin
                    step_phase = PH_FAIL;
                end
            end
            PH_ZERO:
            begin
                if (q_rdata.is_x)
                begin
                    step_phase = PH_HEXPFX;
                end
                else if (q_rdata.is_dec)
                begin
                    do_add     = 1'b1;
                    step_phase = PH_DEC;
                end
                else
                begin
                    step_phase = PH_FAIL;
                end
            end
            PH_HEXPFX, PH_HEX:
            begin
                radix = RADIX_HEX;
                if (q_rdata.is_hex)
                begin
                    do_add     = 1'b1;
                    step_phase = PH_HEX;
                end
                else
                begin
                    step_phase = PH_FAIL;
                end
            end
            PH_BINPFX, PH_BIN:
            begin
                radix = RADIX_BIN;
                if (q_rdata.is_bin)
                begin
                    do_add     = 1'b1;
                    step_phase = PH_BIN;
                end
                else
                begin
                    step_phase = PH_FAIL;
                end
            end
            PH_DEC:
            begin
                if (q_rdata.is_dec)
                begin
                    do_add = 1'b1;
                end
                else
                begin
                    step_phase = PH_FAIL;
                end
            end
            default:
            begin
                step_phase = PH_FAIL;
            end
        endcase
    end

    // constant-radix multiply-add; overflow when the true result needs extra bits
    assign acc_ext = PROD_W'(acc_reg);

    always_comb
    begin
        case (radix)
            RADIX_HEX: prod = (acc_ext << 4) + PROD_W'(q_rdata.digit);
            RADIX_BIN: prod = (acc_ext << 1) + PROD_W'(q_rdata.digit);
            default:   prod = (acc_ext << 3) + (acc_ext << 1) + PROD_W'(q_rdata.digit);
        endcase
    end

    assign step_acc = do_add ? prod[VALUE_WIDTH-1:0] : acc_reg;
    assign step_ovf = ovf_reg || (do_add && (prod[PROD_W-1:VALUE_WIDTH] != '0));

    // word result
    assign word_ok = (step_phase == PH_ZERO) || (step_phase == PH_HEX) ||
                     (step_phase == PH_BIN)  || (step_phase == PH_DEC);
    assign mag_ext = EXT_W'(step_acc);
    assign mag16   = mag_ext[VALUE_OUT_W-1:0];

    // state and output register update
    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        value_next     = value_reg;
        overflow_next  = overflow_reg;
        if (q_pop)
        begin
            if (q_rdata.last)
            begin
                phase_next     = PH_START;
                acc_next       = '0;
                neg_next       = 1'b0;
                ovf_next       = 1'b0;
                out_valid_next = 1'b1;
                ok_next        = word_ok;
                if (word_ok)
                begin
                    value_next    = step_neg ? VALUE_OUT_W'(0) - mag16 : mag16;
                    overflow_next = step_ovf;
                end
                else
                begin
                    value_next    = '0;
                    overflow_next = 1'b0;
                end
            end
            else
            begin
                phase_next = step_phase;
                acc_next   = step_acc;
                neg_next   = step_neg;
                ovf_next   = step_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        ok_reg       <= ok_next;
        value_reg    <= value_next;
        overflow_reg <= overflow_next;
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign value     = signed'(value_reg);
    assign overflow  = overflow_reg;

endmodule

@@ design/signed_radix_number_parser_core.sv @@
// ----------------------------------------------------------------------------
// signed_radix_number_parser_core
// Parses a word of ASCII characters into a signed integer with optional
// minus, hex (0x/0X) or binary (b) prefix, one result per word.
// ----------------------------------------------------------------------------
// The block takes one character request per clock while in_stall is low;
// the parse step is a phase update plus a shift-and-add multiply by 10,
// 16 or 2 on the VALUE_WIDTH accumulator. The request carrying the last
// character is first written into the queue; once it reaches the head and
// the result register is free or being taken, the parse step loads the
// result register. The queue of QUEUE_DEPTH entries lets characters keep
// arriving while a finished result waits on out_stall; once it fills,
// in_stall rises. Words that end in a bad digit, a lone minus or a prefix
// without digits give ok = 0 with value and overflow at zero.
// ----------------------------------------------------------------------------
module signed_radix_number_parser_core #(
    parameter int VALUE_WIDTH = srnp_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = srnp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [srnp_pkg::CHAR_W-1:0]             ch,
    input  logic                                    last_char,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    ok,
    output logic signed [srnp_pkg::VALUE_OUT_W-1:0] value,
    output logic                                    overflow
);
    import srnp_pkg::*;

    char_class_t q_wdata;
    char_class_t q_rdata;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;

    // character classification
    srnp_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last_char (last_char),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // decoupling queue
    srnp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    // parse engine and result register
    srnp_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .value       (value),
        .overflow    (overflow)
    );

endmodule

@@ tb/sv/tb_signed_radix_number_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_radix_number_parser_core
// Streams words of ASCII characters into the parser and checks every word
// result against a cycle-free predictor of the parse. Covers directed corner
// words, random well-formed and broken words under several idle and stall
// mixes, and a long output hold that fills the character queue.
// ----------------------------------------------------------------------------
module tb_signed_radix_number_parser_core;
    import srnp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 80;
    localparam int STREAM_CHARS   = 370;
    localparam int PRESSURE_CHARS = 60;
    localparam int BASE_DEC       = 10;
    localparam int BASE_HEX       = 16;
    localparam int BASE_BIN       = 2;
    localparam int VALUE_MAX      = 65535;

    typedef struct packed {
        logic                   ok;
        logic [VALUE_OUT_W-1:0] value;
        logic                   overflow;
    } word_result_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [CHAR_W-1:0]             ch;
    logic                          last_char;
    logic                          out_valid;
    logic                          out_stall;
    logic                          ok;
    logic signed [VALUE_OUT_W-1:0] value;
    logic                          overflow;

    // predictor state of the word being parsed
    phase_t                 prs_phase;
    logic [VALUE_OUT_W-1:0] prs_acc;
    logic                   prs_neg;
    logic                   prs_ovf;

    word_result_t      expected_words[$];
    logic [CHAR_W-1:0] word_chars[$];
    int                mismatches;
    int                chars_sent;
    int                idle_pct;
    int                stall_pct;
    int                hold_left;
    int                quiet_cycles;

    signed_radix_number_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .value     (value),
        .overflow  (overflow)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        prs_phase = PH_START;
        prs_acc   = '0;
        prs_neg   = 1'b0;
        prs_ovf   = 1'b0;
    endfunction

    function automatic void accumulate(input int base, input int digit);
        int unsigned wide;
        wide = int'(prs_acc) * base + digit;
        if (wide > VALUE_MAX)
            prs_ovf = 1'b1;
        prs_acc = wide[VALUE_OUT_W-1:0];
    endfunction

    // one accepted character; a last character queues the word result
    function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic is_last);
        logic         is_dec;
        int           hex_val;
        word_result_t res;
        is_dec = (c >= CH_0) && (c <= CH_9);
        if (is_dec)
            hex_val = int'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF)
            hex_val = int'(c - CH_LA) + 10;
        else if (c >= CH_UA && c <= CH_UF)
            hex_val = int'(c - CH_UA) + 10;
        else
            hex_val = -1;

        case (prs_phase)
            PH_START:
            begin
                if (c == CH_MINUS && !prs_neg)
                    prs_neg = 1'b1;
                else if (c == CH_0)
                    prs_phase = PH_ZERO;
                else if (is_dec)
                begin
                    accumulate(BASE_DEC, int'(c - CH_0));
                    prs_phase = PH_DEC;
                end
                else if (c == CH_LB)
                    prs_phase = PH_BINPFX;
                else
                    prs_phase = PH_FAIL;
            end
            PH_ZERO:
            begin
                if (c == CH_LX || c == CH_UX)
                    prs_phase = PH_HEXPFX;
                else if (is_dec)
                begin
                    accumulate(BASE_DEC, int'(c - CH_0));
                    prs_phase = PH_DEC;
                end
                else
                    prs_phase = PH_FAIL;
            end
            PH_HEXPFX, PH_HEX:
            begin
                if (hex_val >= 0)
                begin
                    accumulate(BASE_HEX, hex_val);
                    prs_phase = PH_HEX;
                end
                else
                    prs_phase = PH_FAIL;
            end
            PH_BINPFX, PH_BIN:
            begin
                if (c == CH_0 || c == CH_1)
                begin
                    accumulate(BASE_BIN, int'(c - CH_0));
                    prs_phase = PH_BIN;
                end
                else
                    prs_phase = PH_FAIL;
            end
            PH_DEC:
            begin
                if (is_dec)
                    accumulate(BASE_DEC, int'(c - CH_0));
                else
                    prs_phase = PH_FAIL;
            end
            default:
                prs_phase = PH_FAIL;
        endcase

        if (is_last)
        begin
            if (prs_phase == PH_ZERO || prs_phase == PH_HEX ||
                prs_phase == PH_BIN || prs_phase == PH_DEC)
            begin
                res.ok       = 1'b1;
                res.value    = prs_neg ? -prs_acc : prs_acc;
                res.overflow = prs_ovf;
            end
            else
                res = '0;
            expected_words.push_back(res);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic check_result();
        word_result_t want;
        if (expected_words.size() == 0)
            report_mismatch("unexpected result, pending words", 0, 1);
        else
        begin
            want = expected_words.pop_front();
            if (ok !== want.ok)
                report_mismatch("ok", want.ok, ok);
            if (value !== want.value)
                report_mismatch("value", $signed(want.value), value);
            if (overflow !== want.overflow)
                report_mismatch("overflow", want.overflow, overflow);
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                parse_char(ch, last_char);
        end
    end

    // watchdog on cycles with no request accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // receiver: long hold when asked, random stall otherwise
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        ch        <= c;
        last_char <= is_last;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
    endtask

    task automatic send_word();
        foreach (word_chars[i])
            send_char(word_chars[i], i == word_chars.size() - 1);
    endtask

    task automatic send_text(input string s);
        word_chars = {};
        for (int i = 0; i < s.len(); i++)
            word_chars.push_back(s[i]);
        send_word();
    endtask

    // drop valid, wait for every queued word, then let the pipe settle
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // random word generation
    // ------------------------------------------------------------------
    function automatic logic [CHAR_W-1:0] rand_hex_digit();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10)
            return CH_0 + CHAR_W'(r);
        return ($urandom_range(0, 1) ? CH_LA : CH_UA) + CHAR_W'(r - 10);
    endfunction

    task automatic build_random_word();
        int kind;
        int len;
        int pos;
        kind = $urandom_range(0, 99);
        word_chars = {};
        if (kind < 82 && $urandom_range(0, 99) < 40)
            word_chars.push_back(CH_MINUS);
        if (kind < 22 || (kind >= 72 && kind < 77))
        begin
            // decimal, sometimes with a leading zero, now and then wide
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 5);
            if ($urandom_range(0, 5) == 0)
                word_chars.push_back(CH_0);
            repeat (len) word_chars.push_back(CH_0 + CHAR_W'($urandom_range(0, 9)));
        end
        else if (kind < 44 || (kind >= 77 && kind < 82))
        begin
            // hex with either prefix letter
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
            word_chars.push_back(CH_0);
            word_chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
            repeat (len) word_chars.push_back(rand_hex_digit());
        end
        else if (kind < 62)
        begin
            // binary
            len = $urandom_range(1, 18);
            word_chars.push_back(CH_LB);
            repeat (len) word_chars.push_back(CH_0 + CHAR_W'($urandom_range(0, 1)));
        end
        else if (kind < 66)
            word_chars.push_back(CH_0);
        else if (kind < 72)
        begin
            // lone minus or a prefix with no digits
            case ($urandom_range(0, 3))
                0: word_chars.push_back(CH_MINUS);
                1: word_chars.push_back(CH_LB);
                default:
                begin
                    word_chars.push_back(CH_0);
                    word_chars.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                end
            endcase
        end
        else if (kind < 90)
        begin
            // minus with up to three decimal digits on each side
            repeat ($urandom_range(0, 3))
                word_chars.push_back(CH_0 + CHAR_W'($urandom_range(0, 9)));
            word_chars.push_back(CH_MINUS);
            repeat ($urandom_range(0, 3))
                word_chars.push_back(CH_0 + CHAR_W'($urandom_range(0, 9)));
        end
        else
        begin
            // raw bytes over the whole code range
            len = $urandom_range(1, 5);
            repeat (len) word_chars.push_back(CHAR_W'($urandom_range(0, 255)));
        end

        // corrupt one character of some well-formed words
        if (kind >= 72 && kind < 82)
        begin
            pos = $urandom_range(0, word_chars.size() - 1);
            word_chars[pos] = CHAR_W'($urandom_range(0, 255));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        idle_pct  = 0;
        stall_pct = 0;
        send_text("0");
        send_text("-");
        send_text("0X");
        send_text("-b");
        send_text("07");
        send_text("--1");
        send_text("65536");
        send_text("-0xfF");
        send_text("b1");
        // nul and all-ones bytes as single-character words
        word_chars = {8'h00};
        send_word();
        word_chars = {8'hFF};
        send_word();
        wait_drain();
    endtask

    task automatic test_random_stream(input int sender_idle, input int receiver_stall);
        int start_count;
        idle_pct    = sender_idle;
        stall_pct   = receiver_stall;
        start_count = chars_sent;
        while (chars_sent - start_count < STREAM_CHARS)
        begin
            build_random_word();
            send_word();
        end
        wait_drain();
    endtask

    task automatic test_queue_fill();
        int start_count;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_left   = HOLD_CYCLES;
        start_count = chars_sent;
        while (chars_sent - start_count < PRESSURE_CHARS)
        begin
            build_random_word();
            send_word();
        end
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        ch           = '0;
        last_char    = 1'b0;
        mismatches   = 0;
        chars_sent   = 0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_left    = 0;
        quiet_cycles = 0;
        clear_parse();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_stream(0, 0);
        test_random_stream(46, 0);
        test_queue_fill();
        test_random_stream(0, 46);
        test_random_stream(35, 35);

        if (mismatches == 0 && expected_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
